### rtl/cr1u_pkg.sv
// Shared types, constants and helper functions for the rank-one factor update.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package cr1u_pkg;

    localparam int MAX_ORDER = 8;
    localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W     = $clog2(MAX_ORDER + 1);
    localparam int AW        = $clog2(MAX_ORDER * MAX_ORDER);

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_DIAG,
        S_LD_DIAG,
        S_DSQ,
        S_VSQ,
        S_SQ_ADD,
        S_SQRT,
        S_SQ_DONE,
        S_JCHK,
        S_RD_J,
        S_LD_J,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_NEXT_I,
        S_ERD,
        S_EOUT
    } t_state;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DIA = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } t_sat;

    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
    } t_smag;

    // Signed saturation of a sign and magnitude to 32 bits.
    function automatic t_sat sat32(input logic neg, input logic [63:0] mag);
        t_sat s;
        s.ovf = 1'b0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                s.ovf = 1'b1;
                s.val = 32'h8000_0000;
            end else begin
                s.val = 32'(-mag);
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                s.ovf = 1'b1;
                s.val = 32'h7FFF_FFFF;
            end else begin
                s.val = mag[31:0];
            end
        end
        return s;
    endfunction

    // Sum of two products as sign and magnitude; |p| <= 2^62 each.
    function automatic t_smag sum_mag(input logic signed [63:0] p1,
                                      input logic signed [63:0] p2);
        t_smag       r;
        logic [63:0] m1;
        logic [63:0] m2;
        m1 = p1[63] ? 64'(-p1) : 64'(p1);
        m2 = p2[63] ? 64'(-p2) : 64'(p2);
        if (p1[63] == p2[63]) begin
            r.mag = m1 + m2;
            r.neg = p1[63];
        end else if (m1 >= m2) begin
            r.mag = m1 - m2;
            r.neg = p1[63];
        end else begin
            r.mag = m2 - m1;
            r.neg = p2[63];
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [IDX_W-1:0] a,
                                            input logic [IDX_W-1:0] b);
        return AW'(AW'(a) * AW'(MAX_ORDER) + AW'(b));
    endfunction

endpackage

### rtl/cholesky_rank1_update_upper.sv
// Top level of the rank-one Cholesky factor update (upper triangle, Q16.16).
// Depends on cr1u_pkg for types, saturation helpers and store addressing.
`timescale 1ns / 1ps

// One load is taken per cycle (start high, busy low). The request flagged last
// starts the update, and busy stays high until the final entry of the upper
// triangle is shown on the result ports, one entry per o_valid pulse, row-major;
// busy is low in the cycle that shows the final entry. The receiver cannot stall:
// each entry is flagged by o_valid for one cycle only. An update of order n
// is served by one shared 32x32 multiplier and one bit-per-cycle subtract
// unit (32 steps for each square root, 64 steps for each division), with two
// divisions for each off-diagonal entry. Configuration (matrix_size) is taken
// on i_cfg_valid while the block is idle; 0 acts as 1, values above the
// maximum order act as the maximum order.
module cholesky_rank1_update_upper
    import cr1u_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [2:0]         i_row,
    input  logic [2:0]         i_col,
    input  logic signed [31:0] i_value,
    input  logic               i_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    output logic               o_valid,
    output logic [2:0]         o_row_res,
    output logic [2:0]         o_col_res,
    output logic signed [31:0] o_value_res,
    output logic [1:0]         o_status,
    output logic               o_last_res
);

    // stores: written and read in clocked blocks, registered read data
    logic [31:0] f_mem [MAX_ORDER*MAX_ORDER];
    logic [31:0] v_mem [MAX_ORDER];
    logic [31:0] r_frd, r_vrd;
    logic            f_we, v_we;
    logic [AW-1:0]   f_waddr, f_raddr;
    logic [IDX_W-1:0] v_waddr, v_raddr;
    logic [31:0]     f_wdata, v_wdata;

    // control
    t_state r_state, n_state;
    logic [3:0]       r_size;
    logic [CNT_W-1:0] r_n, n_n, r_i, n_i, r_j, n_j;
    logic [1:0]       r_flags, n_flags;
    logic             r_phase, n_phase;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_ostb, n_ostb;

    // datapath
    logic signed [31:0] r_d, n_d, r_vi, n_vi, r_r, n_r, r_uij, n_uij;
    logic signed [31:0] r_vj, n_vj, r_nu, n_nu;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] r_prod, r_p1, n_p1;
    logic [63:0] r_acc, n_acc, r_res, n_res, r_bit, n_bit;
    logic [63:0] r_quo, n_quo;
    logic [31:0] r_drem, n_drem;
    logic [31:0] r_dvs, n_dvs;
    logic        r_qneg, n_qneg;
    logic [2:0]  n_orow, n_ocol;
    logic [31:0] n_oval;
    logic [1:0]  n_ostat;
    logic        n_olast;
    logic [2:0]  r_orow, r_ocol;
    logic [31:0] r_oval;
    logic [1:0]  r_ostat;
    logic        r_olast;

    logic [CNT_W-1:0] ord;
    logic [63:0]      sq_try;
    logic [32:0]      dv_try;
    logic             dv_ge;
    t_smag            sm;
    t_sat             sat;
    t_sat             sat_r;
    logic signed [63:0] p2;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign o_valid     = r_ostb;
    assign o_row_res   = r_orow;
    assign o_col_res   = r_ocol;
    assign o_value_res = r_oval;
    assign o_status    = r_ostat;
    assign o_last_res  = r_olast;

    // order in use
    always_comb begin
        if (r_size == 4'd0)
            ord = CNT_W'(1);
        else if (32'(r_size) > MAX_ORDER)
            ord = CNT_W'(MAX_ORDER);
        else
            ord = CNT_W'(r_size);
    end

    always_ff @(posedge i_clk) begin
        if (f_we)
            f_mem[f_waddr] <= f_wdata;
        if (v_we)
            v_mem[v_waddr] <= v_wdata;
        r_frd <= f_mem[f_raddr];
        r_vrd <= v_mem[v_raddr];
    end

    // shared multiplier, registered
    always_comb begin
        unique case (r_state)
            S_VSQ:   begin mul_a = r_vi;  mul_b = r_vi; end
            S_M1:    begin mul_a = r_uij; mul_b = r_d;  end
            S_M2:    begin mul_a = r_vi;  mul_b = r_vj; end
            S_M3:    begin mul_a = r_r;   mul_b = r_vj; end
            S_M4:    begin mul_a = r_vi;  mul_b = r_nu; end
            default: begin mul_a = r_d;   mul_b = r_d;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // square root and division steps
    assign sq_try = r_res + r_bit;
    assign dv_try = {r_drem, r_quo[63]};
    assign dv_ge  = (dv_try >= {1'b0, r_dvs});
    assign p2     = r_phase ? -r_prod : r_prod;
    assign sm     = sum_mag(r_p1, p2);
    assign sat    = sat32(r_qneg, r_quo);
    assign sat_r  = sat32(1'b0, r_res);

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_flags = r_flags;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_ostb  = 1'b0;
        n_d     = r_d;
        n_vi    = r_vi;
        n_r     = r_r;
        n_uij   = r_uij;
        n_vj    = r_vj;
        n_nu    = r_nu;
        n_p1    = r_p1;
        n_acc   = r_acc;
        n_res   = r_res;
        n_bit   = r_bit;
        n_quo   = r_quo;
        n_drem  = r_drem;
        n_dvs   = r_dvs;
        n_qneg  = r_qneg;
        n_orow  = r_orow;
        n_ocol  = r_ocol;
        n_oval  = r_oval;
        n_ostat = r_ostat;
        n_olast = r_olast;
        f_we    = 1'b0;
        v_we    = 1'b0;
        f_waddr = f_addr(r_i[IDX_W-1:0], r_j[IDX_W-1:0]);
        f_wdata = r_nu;
        v_waddr = r_j[IDX_W-1:0];
        v_wdata = r_nu;
        f_raddr = f_addr(r_i[IDX_W-1:0], r_j[IDX_W-1:0]);
        v_raddr = r_j[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    // out-of-range indices are dropped
                    if (i_mode == 1'b0) begin
                        f_we = (32'(i_row) < MAX_ORDER) && (32'(i_col) < MAX_ORDER);
                        f_waddr = f_addr(IDX_W'(i_row), IDX_W'(i_col));
                        f_wdata = i_value;
                    end else begin
                        v_we    = (32'(i_row) < MAX_ORDER);
                        v_waddr = IDX_W'(i_row);
                        v_wdata = i_value;
                    end
                    if (i_last) begin
                        n_n     = ord;
                        n_i     = '0;
                        n_flags = 2'b00;
                        n_state = S_RD_DIAG;
                    end
                end
            end
            S_RD_DIAG: begin
                f_raddr = f_addr(r_i[IDX_W-1:0], r_i[IDX_W-1:0]);
                v_raddr = r_i[IDX_W-1:0];
                n_state = S_LD_DIAG;
            end
            S_LD_DIAG: begin
                n_d     = r_frd;
                n_vi    = r_vrd;
                n_state = S_DSQ;
            end
            S_DSQ: n_state = S_VSQ;
            S_VSQ: begin
                n_acc   = r_prod;
                n_state = S_SQ_ADD;
            end
            S_SQ_ADD: begin
                n_acc   = r_acc + r_prod;
                n_res   = '0;
                n_bit   = 64'h4000_0000_0000_0000;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_acc >= sq_try) begin
                    n_acc = r_acc - sq_try;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0])
                    n_state = S_SQ_DONE;
            end
            S_SQ_DONE: begin
                n_r     = sat_r.val;
                n_flags[1] = r_flags[1] | sat_r.ovf;
                f_we    = 1'b1;
                f_waddr = f_addr(r_i[IDX_W-1:0], r_i[IDX_W-1:0]);
                f_wdata = sat_r.val;
                if (r_d == 32'sd0)
                    n_flags[0] = 1'b1;
                n_j     = r_i + CNT_W'(1);
                n_state = S_JCHK;
            end
            S_JCHK: begin
                // zero diagonal leaves the rest of the row and the vector alone
                if (r_d != 32'sd0 && r_j < r_n)
                    n_state = S_RD_J;
                else
                    n_state = S_NEXT_I;
            end
            S_RD_J: n_state = S_LD_J;
            S_LD_J: begin
                n_uij   = r_frd;
                n_vj    = r_vrd;
                n_state = S_M1;
            end
            S_M1: n_state = S_M2;
            S_M2: begin
                n_p1    = r_prod;
                n_phase = 1'b0;
                n_state = S_DIV_INIT;
            end
            S_M3: n_state = S_M4;
            S_M4: begin
                n_p1    = r_prod;
                n_phase = 1'b1;
                n_state = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                n_quo  = sm.mag;
                n_drem = '0;
                n_cnt  = '0;
                if (r_phase) begin
                    n_dvs  = r_d[31] ? 32'(-r_d) : 32'(r_d);
                    n_qneg = sm.neg ^ r_d[31];
                end else begin
                    n_dvs  = r_r;
                    n_qneg = sm.neg;
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                n_drem = dv_ge ? 32'(dv_try - {1'b0, r_dvs}) : dv_try[31:0];
                n_quo  = {r_quo[62:0], dv_ge};
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == 6'd63)
                    n_state = S_DIV_END;
            end
            S_DIV_END: begin
                if (r_quo != 64'd0) begin
                    n_nu       = sat.val;
                    n_flags[1] = r_flags[1] | sat.ovf;
                end else begin
                    n_nu = '0;
                end
                if (r_phase) begin
                    v_we    = 1'b1;
                    v_wdata = (r_quo != 64'd0) ? sat.val : 32'd0;
                    n_j     = r_j + CNT_W'(1);
                    n_state = S_JCHK;
                end else begin
                    f_we    = 1'b1;
                    f_wdata = (r_quo != 64'd0) ? sat.val : 32'd0;
                    n_state = S_M3;
                end
            end
            S_NEXT_I: begin
                if (r_i + CNT_W'(1) < r_n) begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_RD_DIAG;
                end else begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_ERD;
                end
            end
            S_ERD: n_state = S_EOUT;
            S_EOUT: begin
                n_ostb  = 1'b1;
                n_orow  = 3'(r_i);
                n_ocol  = 3'(r_j);
                n_oval  = r_frd;
                n_ostat = r_flags[0] ? ST_ZERO_DIA : (r_flags[1] ? ST_SAT : ST_OK);
                n_olast = (r_i == r_n - CNT_W'(1)) && (r_j == r_n - CNT_W'(1));
                if (r_j + CNT_W'(1) < r_n) begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = S_ERD;
                end else if (r_i + CNT_W'(1) < r_n) begin
                    n_i     = r_i + CNT_W'(1);
                    n_j     = r_i + CNT_W'(1);
                    n_state = S_ERD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= 4'd8;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_flags <= 2'b00;
            r_phase <= 1'b0;
            r_cnt   <= '0;
            r_ostb  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready)
                r_size <= i_cfg_data;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_flags <= n_flags;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_ostb  <= n_ostb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_vi    <= n_vi;
        r_r     <= n_r;
        r_uij   <= n_uij;
        r_vj    <= n_vj;
        r_nu    <= n_nu;
        r_p1    <= n_p1;
        r_acc   <= n_acc;
        r_res   <= n_res;
        r_bit   <= n_bit;
        r_quo   <= n_quo;
        r_drem  <= n_drem;
        r_dvs   <= n_dvs;
        r_qneg  <= n_qneg;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_oval  <= n_oval;
        r_ostat <= n_ostat;
        r_olast <= n_olast;
    end

endmodule

### rtl/cr1u_checker.sv
// Port-level checks for the rank-one factor update, bound to the top level.
// Depends on cholesky_rank1_update_upper being compiled first.
`timescale 1ns / 1ps

module cr1u_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_last,
    input logic       o_valid,
    input logic [2:0] o_row_res,
    input logic [2:0] o_col_res,
    input logic       o_last_res
);

    // results before the final one only appear while the update runs
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_res) |-> busy)
        else $error("result shown while idle");

    // a plain load request yields no result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> !o_valid)
        else $error("result after a load request");

    // the request marked last starts the update
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> busy)
        else $error("update did not start");

    a_final_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_res) |=> !o_valid)
        else $error("result after the final entry");

    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_col_res >= o_row_res))
        else $error("entry below the diagonal");

endmodule

bind cholesky_rank1_update_upper cr1u_checker u_cr1u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_last     (i_last),
    .o_valid    (o_valid),
    .o_row_res  (o_row_res),
    .o_col_res  (o_col_res),
    .o_last_res (o_last_res)
);
